/* hdl/rtcof_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcof_pkg
// Shared constants, codes, types and the gain schedule table of the
// round-trip clock offset filter.
// ----------------------------------------------------------------------------
package rtcof_pkg;

	// accepted samples until the gain schedule reaches its end values
	localparam int CONVERGE_SAMPLES = 512;
	// fraction bits of the filter gains
	localparam int GAIN_FRAC_BITS = 16;

	localparam int CNT_W = $clog2(CONVERGE_SAMPLES + 1);
	localparam int IDX_W = $clog2(CONVERGE_SAMPLES);
	localparam int TAB_DEPTH = 1 << IDX_W;
	localparam int GAIN_W = (GAIN_FRAC_BITS > 16) ? GAIN_FRAC_BITS : 16;
	localparam int MUL_A_W = 32;
	localparam int MUL_P_W = MUL_A_W + GAIN_W;
	localparam int E_W = 31;

	// divide by 1000, one hex digit per step
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [19:0] MAX_RTT_RST = 20'd10000;
	localparam logic [19:0] MAX_DEV_RST = 20'd100000;
	localparam logic [7:0] MAX_ORUN_RST = 8'd5;
	localparam logic [15:0] GAIN_START_RST = 16'd3277;
	localparam logic [15:0] GAIN_END_RST = 16'd197;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAX_RTT = 3'd0,
		CFG_MAX_DEV = 3'd1,
		CFG_MAX_ORUN = 3'd2,
		CFG_LEVEL_START = 3'd3,
		CFG_LEVEL_END = 3'd4,
		CFG_TREND_START = 3'd5,
		CFG_TREND_END = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OUTCOME_IGNORED = 3'd0,
		OUTCOME_ACCEPTED = 3'd1,
		OUTCOME_HIGH_RTT = 3'd2,
		OUTCOME_OUTLIER = 3'd3,
		OUTCOME_FILTER_RESET = 3'd4
	} outcome_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_PRE1,
		OP_PRE2,
		OP_PRE3,
		OP_PRE4,
		OP_PRE5,
		OP_IGNORE,
		OP_HIGH_RTT,
		OP_OUTLIER,
		OP_FIRST,
		OP_GA_MUL,
		OP_GA,
		OP_GB,
		OP_SUM,
		OP_BDIFF,
		OP_BMUL_LO,
		OP_BMUL_HI,
		OP_BPROD,
		OP_BRES,
		OP_LNEW,
		OP_TNEW
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic remote_pos;
		logic rtt_ok;
		logic conv;
		logic outlier;
		logic cnt_zero;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIV,
		S_PRE1,
		S_PRE2,
		S_PRE3,
		S_PRE4,
		S_PRE5,
		S_DECIDE,
		S_GA_MUL,
		S_GA,
		S_GB,
		S_SUM,
		S_L_DIFF,
		S_L_MLO,
		S_L_MHI,
		S_L_PROD,
		S_L_RES,
		S_LNEW,
		S_T_DIFF,
		S_T_MLO,
		S_T_MHI,
		S_T_PROD,
		S_T_RES,
		S_TNEW
	} ctrl_state_t;

	typedef logic [E_W-1:0] exp_tab_t [TAB_DEPTH];

	// shift-subtract quotient, used only while building the table
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-k/(2(W-k))) in Q30 for every accepted count k
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] x24;
		logic [63:0] y24;
		logic [63:0] t;
		logic [63:0] term;
		logic signed [63:0] sum;
		int n;
		for (int k = 0; k < TAB_DEPTH; k++) begin
			tab[k] = '0;
			if (k < CONVERGE_SAMPLES) begin
				x24 = udiv(64'(k) << 23, 64'(CONVERGE_SAMPLES - k));
				if (x24 <= (64'd15 << 24)) begin
					y24 = (x24 * 64'd24204406) >> 24;
					n = int'(y24 >> 24);
					t = ((y24 & 64'hFFFFFF) * 64'd744261118) >> 24;
					term = 64'd1 << 30;
					sum = 64'sd1 <<< 30;
					for (int i = 1; i <= 12; i++) begin
						term = udiv((term * t) >> 30, 64'(i));
						if (i[0])
							sum = sum - $signed(term);
						else
							sum = sum + $signed(term);
					end
					tab[k] = E_W'(64'(sum) >> (n & 63));
				end
			end
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* hdl/rtcof_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcof_if
// Valid/ready channels for sync reply words and filter result words.
// ----------------------------------------------------------------------------
interface rtcof_sample_if;
	logic valid;
	logic ready;
	logic [63:0] local_rx_us;
	logic signed [63:0] remote_stamp_ns;
	logic [62:0] origin_stamp_ns;

	modport source (output valid, output local_rx_us, output remote_stamp_ns,
		output origin_stamp_ns, input ready);
	modport sink (input valid, input local_rx_us, input remote_stamp_ns,
		input origin_stamp_ns, output ready);
endinterface

interface rtcof_result_if;
	logic valid;
	logic ready;
	logic [2:0] outcome;
	logic signed [47:0] ofs_est_us;
	logic converged;
	logic [63:0] round_trip_us;
	logic [15:0] high_rtt_run;

	modport source (output valid, output outcome, output ofs_est_us, output converged,
		output round_trip_us, output high_rtt_run, input ready);
	modport sink (input valid, input outcome, input ofs_est_us, input converged,
		input round_trip_us, input high_rtt_run, output ready);
endinterface

/* hdl/rtcof_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcof_ctrl
// Sequencer: steps the datapath through division, sample checks and the
// two filter blends, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module rtcof_ctrl import rtcof_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	ctrl_state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic out_valid_q;
	logic set_out;

	// state register, digit counter, result word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV)
				div_cnt_q <= div_cnt_q + 1'b1;
			else
				div_cnt_q <= '0;
			if (set_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		set_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = S_PRE1;
			end
			S_PRE1: begin cmd.op = OP_PRE1; state_d = S_PRE2; end
			S_PRE2: begin cmd.op = OP_PRE2; state_d = S_PRE3; end
			S_PRE3: begin cmd.op = OP_PRE3; state_d = S_PRE4; end
			S_PRE4: begin cmd.op = OP_PRE4; state_d = S_PRE5; end
			S_PRE5: begin cmd.op = OP_PRE5; state_d = S_DECIDE; end
			S_DECIDE: begin
				// hold until the previous result word is taken
				if (!out_valid_q) begin
					if (!status.remote_pos) begin
						cmd.op = OP_IGNORE;
						set_out = 1'b1;
						state_d = S_IDLE;
					end else if (!status.rtt_ok) begin
						cmd.op = OP_HIGH_RTT;
						set_out = 1'b1;
						state_d = S_IDLE;
					end else if (status.conv && status.outlier) begin
						cmd.op = OP_OUTLIER;
						set_out = 1'b1;
						state_d = S_IDLE;
					end else if (status.cnt_zero) begin
						cmd.op = OP_FIRST;
						set_out = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_GA_MUL;
					end
				end
			end
			S_GA_MUL: begin cmd.op = OP_GA_MUL; state_d = S_GA; end
			S_GA: begin cmd.op = OP_GA; state_d = S_GB; end
			S_GB: begin cmd.op = OP_GB; state_d = S_SUM; end
			S_SUM: begin cmd.op = OP_SUM; state_d = S_L_DIFF; end
			S_L_DIFF: begin cmd.op = OP_BDIFF; state_d = S_L_MLO; end
			S_L_MLO: begin cmd.op = OP_BMUL_LO; state_d = S_L_MHI; end
			S_L_MHI: begin cmd.op = OP_BMUL_HI; state_d = S_L_PROD; end
			S_L_PROD: begin cmd.op = OP_BPROD; state_d = S_L_RES; end
			S_L_RES: begin cmd.op = OP_BRES; state_d = S_LNEW; end
			S_LNEW: begin cmd.op = OP_LNEW; state_d = S_T_DIFF; end
			S_T_DIFF: begin cmd.op = OP_BDIFF; state_d = S_T_MLO; end
			S_T_MLO: begin cmd.op = OP_BMUL_LO; state_d = S_T_MHI; end
			S_T_MHI: begin cmd.op = OP_BMUL_HI; state_d = S_T_PROD; end
			S_T_PROD: begin cmd.op = OP_BPROD; state_d = S_T_RES; end
			S_T_RES: begin cmd.op = OP_BRES; state_d = S_TNEW; end
			S_TNEW: begin
				cmd.op = OP_TNEW;
				set_out = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	// a result is never formed over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		set_out |-> !out_valid_q) else $error("result overwritten");
	// a formed result is offered next cycle
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		set_out |=> out_valid_q) else $error("result not offered");
	// an accepted word starts the divider
	a_load_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DIV)) else $error("no divide after load");
	// the divider runs exactly its digit count
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) |=>
		(state_q == S_PRE1)) else $error("divider length");
`endif

endmodule

/* hdl/rtcof_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcof_dp
// Datapath: divide-by-1000 digit units, offset and round-trip arithmetic,
// gain schedule table, shared multiplier, filter state and result word.
// ----------------------------------------------------------------------------
module rtcof_dp import rtcof_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_status_t             status,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [63:0]            local_rx_us,
	input  logic signed [63:0]     remote_stamp_ns,
	input  logic [62:0]            origin_stamp_ns,
	output logic [2:0]             outcome,
	output logic signed [47:0]     ofs_est_us,
	output logic                   converged,
	output logic [63:0]            round_trip_us,
	output logic [15:0]            high_rtt_run
);

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

	// one hex digit of a divide by 1000: {digit, remainder}
	function automatic logic [13:0] div_digit(input logic [13:0] r);
		logic [3:0] dig;
		dig = '0;
		for (int k = 1; k < 16; k++) begin
			if (r >= 14'(k * 1000))
				dig = 4'(k);
		end
		return {dig, 10'(r - 14'(dig) * 14'd1000)};
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	// level in Q16 to integer, toward zero
	function automatic logic signed [47:0] trunc16(input logic signed [63:0] v);
		logic signed [63:0] b;
		b = v + (v[63] ? 64'sd65535 : 64'sd0);
		return 48'(b >>> 16);
	endfunction

	// scheduled gain from e*|start-end|, rounded, rescaled to the gain format
	function automatic logic [GAIN_W-1:0] sched_gain(input logic [MUL_P_W-1:0] p,
		input logic [15:0] st, input logic [15:0] en);
		logic [MUL_P_W:0] r;
		logic [15:0] mag;
		logic [15:0] g16;
		r = {1'b0, p} + ((MUL_P_W + 1)'(1) << 29);
		mag = 16'(r >> 30);
		g16 = (st >= en) ? en + mag : en - mag;
		return (GAIN_FRAC_BITS >= 16) ? (GAIN_W'(g16) << (GAIN_FRAC_BITS - 16)) :
			GAIN_W'(g16 >> (16 - GAIN_FRAC_BITS));
	endfunction

	// configuration registers
	logic [19:0] max_rtt_q, max_dev_q;
	logic [7:0] max_orun_q;
	logic [15:0] lgs_q, lge_q, tgs_q, tge_q;

	// filter state
	logic signed [63:0] level_q, trend_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0] orun_q;
	logic [15:0] rrun_q;

	// working registers
	logic [63:0] now_q, rem_dvd_q, org_dvd_q;
	logic [9:0] rem_r_q, org_r_q;
	logic remote_pos_q;
	logic [63:0] t_q, rtt_q, sum_q;
	logic rtt_ok_q, outlier_q;
	logic signed [63:0] half_q;
	logic signed [47:0] cur_q, ofs_q;
	logic [E_W-1:0] rom_q;
	logic [MUL_P_W-1:0] prod_q, plo_q;
	logic [GAIN_W-1:0] ga_q, gb_q;
	logic gsel_q, up_q;
	logic signed [63:0] base_q, target_q;
	logic [63:0] mag_q, bprod_q, blend_q;

	// result word
	logic [2:0] res_outcome_q;
	logic signed [47:0] res_offset_q;
	logic res_conv_q;
	logic [63:0] res_rtt_q;
	logic [15:0] res_rrun_q;

	logic conv;
	logic [CNT_W-1:0] cnt_inc;
	logic conv_inc;
	logic [15:0] rrun_inc;
	logic [7:0] orun_inc;
	logic [13:0] rem_step, org_step;
	logic [E_W-1:0] e_sel;
	logic [GAIN_W-1:0] g_sel;
	logic [MUL_A_W-1:0] mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic [MUL_P_W:0] lo_rnd;
	logic signed [48:0] dev_diff;
	logic [48:0] dev;
	logic clear_now;

	assign conv = (cnt_q >= CNT_W'(CONVERGE_SAMPLES));
	assign cnt_inc = conv ? cnt_q : cnt_q + 1'b1;
	assign conv_inc = (cnt_inc >= CNT_W'(CONVERGE_SAMPLES));
	assign rrun_inc = (rrun_q != 16'hFFFF) ? rrun_q + 1'b1 : rrun_q;
	assign orun_inc = (orun_q != 8'hFF) ? orun_q + 1'b1 : orun_q;
	assign clear_now = (orun_inc > max_orun_q);
	assign rem_step = div_digit({rem_r_q, rem_dvd_q[63:60]});
	assign org_step = div_digit({org_r_q, org_dvd_q[63:60]});
	assign e_sel = conv ? '0 : rom_q;
	assign g_sel = gsel_q ? gb_q : ga_q;
	assign lo_rnd = {1'b0, plo_q} + ((MUL_P_W + 1)'(1) << (GAIN_FRAC_BITS - 1));
	assign dev_diff = {cur_q[47], cur_q} - {ofs_q[47], ofs_q};
	assign dev = dev_diff[48] ? 49'(-dev_diff) : 49'(dev_diff);

	// gain schedule table read
	always_ff @(posedge clk) begin
		rom_q <= EXP_TAB[cnt_q[IDX_W-1:0]];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_GA_MUL: begin
				mul_a = MUL_A_W'(e_sel);
				mul_b = GAIN_W'((lgs_q >= lge_q) ? lgs_q - lge_q : lge_q - lgs_q);
			end
			OP_GA: begin
				mul_a = MUL_A_W'(e_sel);
				mul_b = GAIN_W'((tgs_q >= tge_q) ? tgs_q - tge_q : tge_q - tgs_q);
			end
			OP_BMUL_LO: begin
				mul_a = mag_q[31:0];
				mul_b = g_sel;
			end
			OP_BMUL_HI: begin
				mul_a = mag_q[63:32];
				mul_b = g_sel;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rtt_q <= MAX_RTT_RST;
			max_dev_q <= MAX_DEV_RST;
			max_orun_q <= MAX_ORUN_RST;
			lgs_q <= GAIN_START_RST;
			lge_q <= GAIN_END_RST;
			tgs_q <= GAIN_START_RST;
			tge_q <= GAIN_END_RST;
			level_q <= '0;
			trend_q <= '0;
			cnt_q <= '0;
			orun_q <= '0;
			rrun_q <= '0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MAX_RTT: max_rtt_q <= cfg_data;
					CFG_MAX_DEV: max_dev_q <= cfg_data;
					CFG_MAX_ORUN: max_orun_q <= cfg_data[7:0];
					CFG_LEVEL_START: lgs_q <= cfg_data[15:0];
					CFG_LEVEL_END: lge_q <= cfg_data[15:0];
					CFG_TREND_START: tgs_q <= cfg_data[15:0];
					CFG_TREND_END: tge_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_HIGH_RTT: rrun_q <= rrun_inc;
				OP_OUTLIER: begin
					if (clear_now) begin
						level_q <= '0;
						trend_q <= '0;
						cnt_q <= '0;
						orun_q <= '0;
						rrun_q <= '0;
					end else begin
						orun_q <= orun_inc;
					end
				end
				OP_FIRST: begin
					level_q <= {ofs_q, 16'h0000};
					cnt_q <= cnt_inc;
					orun_q <= '0;
					rrun_q <= '0;
				end
				OP_LNEW: level_q <= blend_q;
				OP_TNEW: begin
					trend_q <= blend_q;
					cnt_q <= cnt_inc;
					orun_q <= '0;
					rrun_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// working registers and result word
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				now_q <= local_rx_us;
				rem_dvd_q <= remote_stamp_ns;
				org_dvd_q <= {1'b0, origin_stamp_ns};
				rem_r_q <= '0;
				org_r_q <= '0;
				remote_pos_q <= !remote_stamp_ns[63] && (remote_stamp_ns != '0);
			end
			OP_DIV: begin
				rem_dvd_q <= {rem_dvd_q[59:0], rem_step[13:10]};
				rem_r_q <= rem_step[9:0];
				org_dvd_q <= {org_dvd_q[59:0], org_step[13:10]};
				org_r_q <= org_step[9:0];
			end
			OP_PRE1: begin
				t_q <= now_q - {rem_dvd_q[62:0], 1'b0};
				rtt_q <= now_q - org_dvd_q;
			end
			OP_PRE2: begin
				sum_q <= t_q + org_dvd_q;
				rtt_ok_q <= (rtt_q < 64'(max_rtt_q));
			end
			OP_PRE3: begin
				half_q <= ($signed(sum_q) + $signed({63'd0, sum_q[63]})) >>> 1;
				cur_q <= trunc16(level_q);
			end
			OP_PRE4: begin
				if (half_q[63:47] == {17{half_q[63]}})
					ofs_q <= half_q[47:0];
				else
					ofs_q <= half_q[63] ? S48_MIN : S48_MAX;
			end
			OP_PRE5: outlier_q <= (dev > 49'(max_dev_q));
			OP_IGNORE: begin
				res_outcome_q <= OUTCOME_IGNORED;
				res_offset_q <= cur_q;
				res_conv_q <= conv;
				res_rtt_q <= '0;
				res_rrun_q <= rrun_q;
			end
			OP_HIGH_RTT: begin
				res_outcome_q <= OUTCOME_HIGH_RTT;
				res_offset_q <= cur_q;
				res_conv_q <= conv;
				res_rtt_q <= rtt_q;
				res_rrun_q <= rrun_inc;
			end
			OP_OUTLIER: begin
				res_rtt_q <= rtt_q;
				if (clear_now) begin
					res_outcome_q <= OUTCOME_FILTER_RESET;
					res_offset_q <= '0;
					res_conv_q <= 1'b0;
					res_rrun_q <= '0;
				end else begin
					res_outcome_q <= OUTCOME_OUTLIER;
					res_offset_q <= cur_q;
					res_conv_q <= conv;
					res_rrun_q <= rrun_q;
				end
			end
			OP_FIRST: begin
				res_outcome_q <= OUTCOME_ACCEPTED;
				res_offset_q <= ofs_q;
				res_conv_q <= conv_inc;
				res_rtt_q <= rtt_q;
				res_rrun_q <= '0;
			end
			OP_GA: ga_q <= sched_gain(prod_q, lgs_q, lge_q);
			OP_GB: gb_q <= sched_gain(prod_q, tgs_q, tge_q);
			OP_SUM: begin
				base_q <= sat_add(level_q, trend_q);
				target_q <= {ofs_q, 16'h0000};
				gsel_q <= 1'b0;
			end
			OP_BDIFF: begin
				up_q <= (target_q >= base_q);
				mag_q <= (target_q >= base_q) ? 64'(target_q - base_q) :
					64'(base_q - target_q);
			end
			OP_BMUL_HI: plo_q <= prod_q;
			OP_BPROD: bprod_q <= (64'(prod_q) << (32 - GAIN_FRAC_BITS)) +
				64'(lo_rnd >> GAIN_FRAC_BITS);
			OP_BRES: blend_q <= up_q ? 64'(base_q) + bprod_q : 64'(base_q) - bprod_q;
			OP_LNEW: begin
				target_q <= sat_sub(blend_q, level_q);
				base_q <= trend_q;
				gsel_q <= 1'b1;
			end
			OP_TNEW: begin
				res_outcome_q <= OUTCOME_ACCEPTED;
				res_offset_q <= trunc16(level_q);
				res_conv_q <= conv_inc;
				res_rtt_q <= rtt_q;
				res_rrun_q <= '0;
			end
			default: ;
		endcase
	end

	assign status.remote_pos = remote_pos_q;
	assign status.rtt_ok = rtt_ok_q;
	assign status.conv = conv;
	assign status.outlier = outlier_q;
	assign status.cnt_zero = (cnt_q == '0);

	assign outcome = res_outcome_q;
	assign ofs_est_us = res_offset_q;
	assign converged = res_conv_q;
	assign round_trip_us = res_rtt_q;
	assign high_rtt_run = res_rrun_q;

`ifndef NO_ASSERTIONS
	// accepted count never passes the convergence window
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CONVERGE_SAMPLES)) else $error("count overflow");
	// a filter reset leaves all state cleared
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUTLIER && clear_now) |=>
		(level_q == '0 && trend_q == '0 && cnt_q == '0)) else $error("clear incomplete");
`endif

endmodule

/* hdl/round_trip_clock_offset_filter.sv */
`timescale 1ns / 1ps
// Sequence: a result word forms after the 16-step divide-by-1000 and the checks
// when the reply is ignored, rejected, an outlier or the first sample, and after
// the level and trend blends on the shared multiplier when it drives the filter.
// One reply at a time; a result waits until the previous one is taken.
// Reset: asynchronous; clears filter state and loads the register defaults.
// ----------------------------------------------------------------------------
// round_trip_clock_offset_filter
// Clock offset estimator from round-trip sync replies with a Holt
// level/trend filter on a scheduled gain.
// ----------------------------------------------------------------------------
module round_trip_clock_offset_filter import rtcof_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	rtcof_sample_if.sink           sample,
	rtcof_result_if.source         result,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	dp_cmd_t cmd;
	dp_status_t status;

	// sequencer
	rtcof_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath
	rtcof_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.local_rx_us     (sample.local_rx_us),
		.remote_stamp_ns (sample.remote_stamp_ns),
		.origin_stamp_ns (sample.origin_stamp_ns),
		.outcome         (result.outcome),
		.ofs_est_us      (result.ofs_est_us),
		.converged       (result.converged),
		.round_trip_us   (result.round_trip_us),
		.high_rtt_run    (result.high_rtt_run)
	);

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-trip clock offset filter. Sync reply
// words are queued per phase and sent by a clocked driver. A monitor predicts
// each result word from a local level/trend filter model and compares the
// block's result words against it. Register settings change between phases.
// Both sides insert random idle bursts, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import rtcof_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;
	localparam logic signed [63:0] OFS_HI = 64'sd140737488355327;
	localparam logic signed [63:0] OFS_LO = -64'sd140737488355328;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

	typedef struct {
		logic [63:0] rx_us;
		logic signed [63:0] remote_ns;
		logic [62:0] origin_ns;
	} reply_t;

	typedef struct {
		outcome_t outcome;
		logic signed [47:0] ofs_est_us;
		logic converged;
		logic [63:0] rtt_us;
		logic [15:0] rtt_run;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rtcof_sample_if sample_ch ();
	rtcof_result_if result_ch ();

	round_trip_clock_offset_filter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch.sink),
		.result(result_ch.source),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// model register copies and filter state
	logic [63:0] rtt_limit, dev_limit, orun_limit;
	logic [63:0] alpha_start, alpha_end, beta_start, beta_end;
	logic signed [63:0] level_q16, trend_q16;
	int unsigned sample_cnt, outlier_cnt, high_rtt_cnt;

	reply_t pending_replies[$];
	estimate_t expected_estimates[$];
	int mismatches = 0;
	int results_seen = 0;
	int idle_run = 0;
	bit quiet = 0;

	// stimulus generator state
	logic [63:0] now_us = 64'd1_000_000_000_000;
	logic signed [63:0] true_ofs = 64'sd0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// exp(-k/(2(W-k))) in Q30
	function automatic logic [63:0] decay_q30(int unsigned k);
		logic [63:0] x24, y24, t, term;
		logic signed [63:0] acc;
		int unsigned n;
		x24 = (64'(k) << 23) / 64'(CONVERGE_SAMPLES - k);
		if (x24 > (64'd15 << 24))
			return 64'd0;
		y24 = (x24 * 64'd24204406) >> 24;
		n = int'(y24 >> 24);
		t = ((y24 & 64'hFFFFFF) * 64'd744261118) >> 24;
		term = 64'd1 << 30;
		acc = 64'sd1 <<< 30;
		for (int i = 1; i <= 12; i++) begin
			term = ((term * t) >> 30) / 64'(i);
			if (i % 2 == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		return 64'(acc) >> (n & 63);
	endfunction

	function automatic logic [63:0] sched_gain(logic [63:0] g0, logic [63:0] g1,
			logic [63:0] e30);
		if (g0 >= g1)
			return g1 + ((e30 * (g0 - g1) + (64'd1 << 29)) >> 30);
		return g1 - ((e30 * (g1 - g0) + (64'd1 << 29)) >> 30);
	endfunction

	// base + g*(target - base), magnitude rounded half up
	function automatic logic signed [63:0] pull_toward(logic signed [63:0] base,
			logic signed [63:0] target, logic [63:0] g);
		logic up;
		logic [63:0] mag, hi, lo, prod;
		up = target >= base;
		mag = up ? 64'(target) - 64'(base) : 64'(base) - 64'(target);
		hi = mag >> 32;
		lo = mag & 64'hFFFFFFFF;
		prod = ((hi * g) << (32 - GAIN_FRAC_BITS)) +
			((lo * g + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS);
		return up ? $signed(64'(base) + prod) : $signed(64'(base) - prod);
	endfunction

	function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(S64_MAX)) return S64_MAX;
		if (s < 65'(S64_MIN)) return S64_MIN;
		return s[63:0];
	endfunction

	function automatic void clear_filter();
		level_q16 = '0;
		trend_q16 = '0;
		sample_cnt = 0;
		outlier_cnt = 0;
		high_rtt_cnt = 0;
	endfunction

	// next result word of the filter for one reply
	function automatic estimate_t estimate_offset(reply_t r);
		estimate_t e;
		logic [63:0] origin_us, far_us, sum, dev, ga, gb, e30;
		logic signed [63:0] ofs, cur, x, s, prev;
		logic conv;
		e.outcome = OUTCOME_IGNORED;
		e.rtt_us = '0;
		origin_us = {1'b0, r.origin_ns} / 64'd1000;
		if (r.remote_ns > 0) begin
			far_us = 64'(r.remote_ns) / 64'd1000;
			sum = origin_us + r.rx_us - 2 * far_us;
			ofs = $signed(sum) / 64'sd2;
			cur = level_q16 / 64'sd65536;
			conv = sample_cnt >= CONVERGE_SAMPLES;
			if (ofs > OFS_HI) ofs = OFS_HI;
			if (ofs < OFS_LO) ofs = OFS_LO;
			e.rtt_us = r.rx_us - origin_us;
			dev = cur >= ofs ? 64'(cur - ofs) : 64'(ofs - cur);
			if (e.rtt_us < rtt_limit) begin
				if (conv && dev > dev_limit) begin
					if (outlier_cnt < 255) outlier_cnt++;
					if (outlier_cnt > orun_limit) begin
						clear_filter();
						e.outcome = OUTCOME_FILTER_RESET;
					end else begin
						e.outcome = OUTCOME_OUTLIER;
					end
				end else begin
					x = ofs <<< 16;
					if (sample_cnt == 0) begin
						level_q16 = x;
					end else begin
						if (conv) begin
							ga = alpha_end;
							gb = beta_end;
						end else begin
							e30 = decay_q30(sample_cnt);
							ga = sched_gain(alpha_start, alpha_end, e30);
							gb = sched_gain(beta_start, beta_end, e30);
						end
						prev = level_q16;
						s = sat_sum(level_q16, trend_q16);
						level_q16 = pull_toward(s, x, ga);
						trend_q16 = pull_toward(trend_q16, sat_sum(level_q16,
							(prev == S64_MIN) ? S64_MAX : -prev) +
							((prev == S64_MIN && level_q16 < 0) ? 64'sd1 : 64'sd0), gb);
					end
					if (sample_cnt < CONVERGE_SAMPLES) sample_cnt++;
					outlier_cnt = 0;
					high_rtt_cnt = 0;
					e.outcome = OUTCOME_ACCEPTED;
				end
			end else begin
				if (high_rtt_cnt < 65535) high_rtt_cnt++;
				e.outcome = OUTCOME_HIGH_RTT;
			end
		end
		cur = level_q16 / 64'sd65536;
		e.ofs_est_us = cur[47:0];
		e.converged = sample_cnt >= CONVERGE_SAMPLES;
		e.rtt_run = high_rtt_cnt[15:0];
		return e;
	endfunction

	// reply driver
	int gap_cnt;
	always @(posedge clk or negedge arst_n) begin
		reply_t r;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.local_rx_us <= '0;
			sample_ch.remote_stamp_ns <= '0;
			sample_ch.origin_stamp_ns <= '0;
			gap_cnt <= 0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (gap_cnt != 0) begin
				gap_cnt <= gap_cnt - 1;
				sample_ch.valid <= 1'b0;
			end else if (pending_replies.size() != 0) begin
				r = pending_replies.pop_front();
				sample_ch.local_rx_us <= r.rx_us;
				sample_ch.remote_stamp_ns <= r.remote_ns;
				sample_ch.origin_stamp_ns <= r.origin_ns;
				sample_ch.valid <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					gap_cnt <= $urandom_range(1, 19);
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	int stall_cnt, hold_cnt;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_cnt <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			result_ch.ready <= 1'b0;
		end else if (!hold_done && results_seen >= 300) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
			result_ch.ready <= 1'b0;
		end else if (stall_cnt != 0) begin
			stall_cnt <= stall_cnt - 1;
			result_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			stall_cnt <= $urandom_range(0, 18);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// predict on accepted replies, check accepted results, watchdog
	always @(posedge clk) begin
		reply_t r;
		estimate_t want;
		bit took;
		took = 1'b0;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				r.rx_us = sample_ch.local_rx_us;
				r.remote_ns = sample_ch.remote_stamp_ns;
				r.origin_ns = sample_ch.origin_stamp_ns;
				expected_estimates.push_back(estimate_offset(r));
				took = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				took = 1'b1;
				results_seen <= results_seen + 1;
				if (expected_estimates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: outcome %0d offset %0d",
							result_ch.outcome, result_ch.ofs_est_us);
				end else begin
					want = expected_estimates.pop_front();
					if (result_ch.outcome !== want.outcome ||
							result_ch.ofs_est_us !== want.ofs_est_us ||
							result_ch.converged !== want.converged ||
							result_ch.round_trip_us !== want.rtt_us ||
							result_ch.high_rtt_run !== want.rtt_run) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch at word %0d: exp outcome %0d offset %0d ",
								"conv %0d rtt %0d run %0d / got %0d %0d %0d %0d %0d"},
								results_seen, want.outcome, want.ofs_est_us,
								want.converged, want.rtt_us, want.rtt_run,
								result_ch.outcome, result_ch.ofs_est_us,
								result_ch.converged, result_ch.round_trip_us,
								result_ch.high_rtt_run);
					end
				end
			end
			if (took) begin
				idle_run <= 0;
			end else if (idle_run >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_run <= idle_run + 1;
			end
		end
	end

	// one register write, model copy updated alongside
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MAX_RTT: rtt_limit = 64'(val);
			CFG_MAX_DEV: dev_limit = 64'(val);
			CFG_MAX_ORUN: orun_limit = 64'(val[7:0]);
			CFG_LEVEL_START: alpha_start = 64'(val[15:0]);
			CFG_LEVEL_END: alpha_end = 64'(val[15:0]);
			CFG_TREND_START: beta_start = 64'(val[15:0]);
			CFG_TREND_END: beta_end = 64'(val[15:0]);
			default: ;
		endcase
	endtask

	task automatic write_all(logic [19:0] rtt, logic [19:0] dev, logic [7:0] orun,
			logic [15:0] as, logic [15:0] ae, logic [15:0] bs, logic [15:0] be);
		write_reg(CFG_MAX_RTT, rtt);
		write_reg(CFG_MAX_DEV, dev);
		write_reg(CFG_MAX_ORUN, 20'(orun));
		write_reg(CFG_LEVEL_START, 20'(as));
		write_reg(CFG_LEVEL_END, 20'(ae));
		write_reg(CFG_TREND_START, 20'(bs));
		write_reg(CFG_TREND_END, 20'(be));
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_replies.size() != 0 || expected_estimates.size() != 0 ||
				sample_ch.valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic void push_raw(logic [63:0] l, logic [63:0] rm, logic [62:0] o);
		reply_t r;
		r.rx_us = l;
		r.remote_ns = $signed(rm);
		r.origin_ns = o;
		pending_replies.push_back(r);
	endfunction

	// well-formed reply with a given offset and round trip
	function automatic void push_sync(logic signed [63:0] ofs, logic [63:0] rtt);
		logic [63:0] far_us;
		now_us = now_us + 64'($urandom_range(1000, 2_000_000));
		far_us = now_us + rtt / 2 - 64'(ofs);
		push_raw(now_us + rtt, far_us * 1000 + 64'($urandom_range(0, 999)),
			63'(now_us * 1000 + 64'($urandom_range(0, 999))));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly clean sync traffic with outlier bursts, slow rtt and noise
	function automatic void push_mix(int count);
		int pick;
		int burst;
		logic [63:0] lim;
		lim = (rtt_limit == 0) ? 64'd1 : rtt_limit;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 199) == 0)
				true_ofs = $signed(64'($urandom_range(0, 4_000_000))) - 64'sd2_000_000;
			if (pick < 74) begin
				push_sync(true_ofs + $signed(64'($urandom_range(0, 100))) - 64'sd50,
					64'($urandom_range(0, 32'(lim - 1))));
			end else if (pick < 84) begin
				burst = $urandom_range(1, 8);
				for (int b = 0; b < burst; b++)
					push_sync(true_ofs + 64'sd2 * $signed(dev_limit) + 64'sd1000 +
						$signed(64'($urandom_range(0, 500_000))), 64'd0);
			end else if (pick < 91) begin
				push_sync(true_ofs, rtt_limit + 64'($urandom_range(0, 5000)));
			end else if (pick < 94) begin
				push_raw(rand64(), {1'b1, 63'(rand64())}, 63'(rand64()));
			end else begin
				push_raw(rand64(), rand64(), 63'(rand64()));
			end
		end
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rtt_limit = 64'(MAX_RTT_RST);
		dev_limit = 64'(MAX_DEV_RST);
		orun_limit = 64'(MAX_ORUN_RST);
		alpha_start = 64'(GAIN_START_RST);
		alpha_end = 64'(GAIN_END_RST);
		beta_start = 64'(GAIN_START_RST);
		beta_end = 64'(GAIN_END_RST);
		clear_filter();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, ignored replies, saturated offset, wrapping stamps
		push_raw(64'd0, 64'h8000000000000000, 63'd0);
		push_raw('1, '1, '1);
		push_raw(64'd5000, 64'd0, 63'd1000);
		push_raw(64'd5000, 64'd1, 63'd4_000_000);
		push_raw(64'd0, 64'h7FFFFFFFFFFFFFFF, '1);
		push_raw('1, 64'd1, '1);
		push_raw('1, 64'd1000, 63'd0);
		push_raw(64'd100, 64'd50_000, 63'd99_000);
		push_raw(64'd100, 64'd50_000, 63'd200_000);
		push_sync(64'sd1234, 64'd9999);
		push_sync(64'sd1234, 64'd10000);
		push_sync(64'sd1200, 64'd0);
		push_sync(-64'sd77, 64'd500);
		push_sync(64'sd0, 64'd20000);
		push_sync(64'sd10, 64'd1);
		push_raw(64'd0, 64'd999, 63'd0);
		wait_drained();

		// gain and threshold extremes
		write_all(20'd1000000, 20'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
		push_mix(150);
		wait_drained();

		// zero round-trip limit rejects every sample
		write_all(20'd0, 20'($urandom_range(0, 1000000)), 8'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		push_mix(30);
		wait_drained();

		// long run that converges, with outlier runs clearing the filter
		write_all(MAX_RTT_RST, MAX_DEV_RST, 8'd3, GAIN_START_RST, GAIN_END_RST,
			GAIN_START_RST, GAIN_END_RST);
		true_ofs = 64'sd3500;
		for (int i = 0; i < 600; i++)
			push_sync(true_ofs + $signed(64'($urandom_range(0, 40))) - 64'sd20,
				64'($urandom_range(0, 9999)));
		push_mix(200);
		wait_drained();

		// wide thresholds, random gains, no idling
		quiet = 1'b1;
		write_all(20'd1000000, 20'd1000000, 8'd255, 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		push_mix(250);
		wait_drained();

		if (mismatches == 0 && expected_estimates.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
hdl/rtcof_pkg.sv
hdl/rtcof_if.sv
hdl/rtcof_ctrl.sv
hdl/rtcof_dp.sv
hdl/round_trip_clock_offset_filter.sv
dv/testbench.sv
